@@ rtl/ght_pkg.sv @@
`default_nettype none

package ght_pkg;

	localparam int SLOTS    = 128;
	localparam int GEN_BITS = 16;
	localparam int REF_BITS = 16;
	localparam int OBJ_BITS = 32;
	localparam int IDX_BITS = $clog2(SLOTS);
	localparam int HND_BITS = GEN_BITS + IDX_BITS;

	// free-slot search: groups of eight, one group picked per cycle
	localparam int GRP_SIZE  = 8;
	localparam int GRP_LBITS = 3;
	localparam int NGRP      = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_BITS  = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int PAD_SLOTS = NGRP * GRP_SIZE;
	localparam int SEL_BITS  = GRP_BITS + GRP_LBITS;

	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [IDX_BITS:0]   hint_t;
	typedef logic [GEN_BITS-1:0] gen_t;
	typedef logic [REF_BITS-1:0] ref_t;
	typedef logic [OBJ_BITS-1:0] obj_t;
	typedef logic [HND_BITS-1:0] hnd_t;

	localparam gen_t  GEN_MAX  = {GEN_BITS{1'b1}};
	localparam gen_t  GEN_INIT = gen_t'(1);
	localparam ref_t  REF_MAX  = {REF_BITS{1'b1}};
	localparam ref_t  REF_ONE  = ref_t'(1);
	localparam hint_t HINT_END = hint_t'(SLOTS);

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RETAIN  = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_LOOKUP  = 2'd3
	} ght_req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_FULL     = 2'd2,
		ST_OVERFLOW = 2'd3
	} ght_status_t;

	typedef struct packed {
		ght_req_t req_type;
		hnd_t     handle_in;
		obj_t     object_in;
	} ght_in_t;

	typedef struct packed {
		ght_status_t status;
		hnd_t        handle_out;
		obj_t        object_out;
		ref_t        ref_count;
		logic        freed;
	} ght_out_t;

	typedef struct packed {
		gen_t gen;
		ref_t refs;
	} tbl_word_t;

	typedef struct packed {
		logic accept;
		logic search;
		logic commit;
	} ght_cmd_t;

	typedef struct packed {
		logic alloc_req;
	} ght_sts_t;

endpackage

`default_nettype wire

@@ rtl/ght_ctrl.sv @@
`default_nettype none

module ght_ctrl
	import ght_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	input  wire ght_sts_t sts,
	output ght_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_EXEC   = 3'b100
	} ght_state_t;

	ght_state_t state_q, state_d;
	logic       rsp_valid_q;
	logic       out_free;

	always_comb begin
		req_ready  = (state_q == S_IDLE);
		out_free   = !rsp_valid_q || rsp_ready;
		cmd.accept = req_valid && req_ready;
		cmd.search = (state_q == S_SEARCH);
		cmd.commit = (state_q == S_EXEC) && out_free;
		state_d    = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					state_d = sts.alloc_req ? S_SEARCH : S_EXEC;
				end
			end
			S_SEARCH: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				// hold here until the output register can take the result
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

@@ rtl/ght_dpath.sv @@
`default_nettype none

module ght_dpath
	import ght_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ght_in_t  req,
	input  wire ght_cmd_t cmd,
	output ght_sts_t      sts,
	output ght_out_t      rsp
);

	// per-slot flags; tvld_q marks table entries written since reset
	logic [SLOTS-1:0]     busy_q, maxed_q, tvld_q;
	logic [SLOTS-1:0]     elig;
	logic [PAD_SLOTS-1:0] elig_pad;

	tbl_word_t tbl_mem [SLOTS];
	obj_t      obj_mem [SLOTS];
	tbl_word_t tbl_rd_q;
	logic      rd_vld_q;
	obj_t      obj_rd_q;

	ght_req_t req_type_q;
	hnd_t     hnd_q;
	obj_t     obj_in_q;
	hint_t    hint_q;
	idx_t     slot_q;
	logic     found_q;
	ght_out_t rsp_q;

	logic                 hint_ok;
	logic                 hint_ok_s1;
	logic [NGRP-1:0]      grp_any, grp_any_s1;
	logic [GRP_LBITS-1:0] grp_low [NGRP];
	logic [GRP_LBITS-1:0] grp_low_s1 [NGRP];

	logic [GRP_BITS-1:0]  sel_grp;
	logic [GRP_LBITS-1:0] sel_low;
	logic [SEL_BITS-1:0]  sel_wide;
	logic                 sel_any;
	idx_t                 srch_idx;
	logic                 srch_found;
	idx_t                 in_idx;
	idx_t                 rd_addr;

	gen_t      gen_cur, gen_nxt, h_gen;
	ref_t      refs_cur, refs_rel;
	logic      in_range, hvalid;
	tbl_word_t tbl_wd;
	logic      tbl_we, obj_we, set_busy, clr_busy, set_maxed, hint_ld;
	hint_t     hint_d;
	ght_out_t  res;

	assign sts.alloc_req = (req.req_type == REQ_ALLOC);
	assign in_idx        = req.handle_in[IDX_BITS-1:0];

	// group-level priority encode, registered when a request is accepted
	always_comb begin
		elig               = ~busy_q & ~maxed_q;
		elig_pad           = '0;
		elig_pad[SLOTS-1:0] = elig;
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g] = |elig_pad[g*GRP_SIZE +: GRP_SIZE];
			grp_low[g] = '0;
			for (int b = GRP_SIZE - 1; b >= 0; b--) begin
				if (elig_pad[g*GRP_SIZE + b]) begin
					grp_low[g] = GRP_LBITS'(b);
				end
			end
		end
		hint_ok = (hint_q < HINT_END) && elig[hint_q[IDX_BITS-1:0]];
	end

	always_comb begin
		sel_grp = '0;
		sel_low = '0;
		sel_any = 1'b0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				sel_any = 1'b1;
				sel_grp = GRP_BITS'(g);
				sel_low = grp_low_s1[g];
			end
		end
		sel_wide   = {sel_grp, sel_low};
		srch_idx   = hint_ok_s1 ? hint_q[IDX_BITS-1:0] : sel_wide[IDX_BITS-1:0];
		srch_found = hint_ok_s1 || sel_any;
		rd_addr    = cmd.search ? srch_idx : in_idx;
	end

	// execute: handle check and slot update
	always_comb begin
		gen_cur   = rd_vld_q ? tbl_rd_q.gen : GEN_INIT;
		refs_cur  = rd_vld_q ? tbl_rd_q.refs : '0;
		gen_nxt   = gen_cur + GEN_INIT;
		refs_rel  = (refs_cur != '0) ? refs_cur - REF_ONE : '0;
		h_gen     = hnd_q[HND_BITS-1:IDX_BITS];
		in_range  = ({1'b0, slot_q} < HINT_END);
		hvalid    = (hnd_q != '0) && in_range && busy_q[slot_q] && (gen_cur == h_gen);
		res       = '0;
		tbl_wd    = '{gen: gen_cur, refs: refs_cur};
		tbl_we    = 1'b0;
		obj_we    = 1'b0;
		set_busy  = 1'b0;
		clr_busy  = 1'b0;
		set_maxed = 1'b0;
		hint_ld   = 1'b0;
		hint_d    = {1'b0, slot_q};
		case (req_type_q)
			REQ_ALLOC: begin
				if (found_q) begin
					tbl_wd.refs    = REF_ONE;
					tbl_we         = 1'b1;
					obj_we         = 1'b1;
					set_busy       = 1'b1;
					hint_ld        = 1'b1;
					hint_d         = {1'b0, slot_q} + hint_t'(1);
					res.status     = ST_OK;
					res.handle_out = {gen_cur, slot_q};
					res.object_out = obj_in_q;
					res.ref_count  = REF_ONE;
				end else begin
					res.status = ST_FULL;
				end
			end
			default: begin
				if (!hvalid) begin
					res.status = ST_INVALID;
				end else begin
					res.status     = ST_OK;
					res.handle_out = {gen_cur, slot_q};
					res.object_out = obj_rd_q;
					res.ref_count  = refs_cur;
					case (req_type_q)
						REQ_RETAIN: begin
							if (refs_cur == REF_MAX) begin
								res.status     = ST_OVERFLOW;
								res.handle_out = '0;
							end else begin
								tbl_wd.refs   = refs_cur + REF_ONE;
								tbl_we        = 1'b1;
								res.ref_count = tbl_wd.refs;
							end
						end
						REQ_RELEASE: begin
							tbl_wd.refs   = refs_rel;
							tbl_we        = 1'b1;
							res.ref_count = refs_rel;
							if (refs_rel == '0) begin
								// last reference: free the slot, retire this generation
								tbl_wd.gen = gen_nxt;
								clr_busy   = 1'b1;
								set_maxed  = (gen_nxt == GEN_MAX);
								hint_ld    = 1'b1;
								res.freed  = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept || cmd.search) begin
			tbl_rd_q <= tbl_mem[rd_addr];
		end
		if (cmd.accept) begin
			obj_rd_q <= obj_mem[in_idx];
		end
		if (cmd.commit && tbl_we) begin
			tbl_mem[slot_q] <= tbl_wd;
		end
		if (cmd.commit && obj_we) begin
			obj_mem[slot_q] <= obj_in_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_type_q <= req.req_type;
			hnd_q      <= req.handle_in;
			obj_in_q   <= req.object_in;
			grp_any_s1 <= grp_any;
			grp_low_s1 <= grp_low;
			hint_ok_s1 <= hint_ok;
			slot_q     <= in_idx;
		end else if (cmd.search) begin
			slot_q  <= srch_idx;
			found_q <= srch_found;
		end
		if (cmd.accept || cmd.search) begin
			rd_vld_q <= tvld_q[rd_addr];
		end
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			maxed_q <= '0;
			tvld_q  <= '0;
			hint_q  <= '0;
		end else if (cmd.commit) begin
			if (tbl_we) begin
				tvld_q[slot_q] <= 1'b1;
			end
			if (set_busy) begin
				busy_q[slot_q] <= 1'b1;
			end
			if (clr_busy) begin
				busy_q[slot_q] <= 1'b0;
			end
			if (set_maxed) begin
				maxed_q[slot_q] <= 1'b1;
			end
			if (hint_ld) begin
				hint_q <= hint_d;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

@@ rtl/generational_handle_table_core.sv @@
// Generational handle table with reference counts.
// Request channel (req_valid/req_ready/req) carries alloc, retain, release
// or lookup; response channel (rsp_valid/rsp_ready/rsp) returns one result
// per request, in order.
// Retain, release and lookup read the slot at acceptance, then execute and
// register the result; alloc adds a search step that picks the free slot
// from a registered per-group priority encode, then reads the slot's
// generation. One request is in flight at a time; the single-port slot
// table read and the read-modify-write in the execute cycle set the pace.
// Reset clears all slots to free with count 0 and generation 1; no sweep
// is needed, so requests are accepted right after reset.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the following request finishes its
// table read and then waits in execute, with no state change, until the
// output register is free.
`default_nettype none

module generational_handle_table_core
	import ght_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	input  wire ght_in_t req,
	output logic         rsp_valid,
	input  wire logic    rsp_ready,
	output ght_out_t     rsp
);

	ght_cmd_t cmd;
	ght_sts_t sts;

	ght_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ght_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_INVALID || rsp.status == ST_FULL) |->
		(rsp.handle_out == '0) && (rsp.object_out == '0) && (rsp.ref_count == '0)
		&& !rsp.freed)
		else $error("failed request returned nonzero fields");

	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.freed |-> (rsp.status == ST_OK) && (rsp.ref_count == '0))
		else $error("freed without reaching zero references");

	a_ok_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_OK) |-> (rsp.handle_out != '0))
		else $error("successful request returned null handle");

endmodule

`default_nettype wire
